>>> hw/rtl/pesa_pkg.sv
// Shared types and constants for the projective eta slice assigner.
package pesa_pkg;

	localparam int SLICE_COUNT = 8;
	localparam int Q_FRAC      = 14;

	typedef logic        [3:0]  layer_t;
	typedef logic signed [16:0] coord_z_t;
	typedef logic        [13:0] radius_t;
	typedef logic signed [13:0] vtx_t;
	typedef logic        [12:0] hw_t;
	typedef logic        [13:0] wslope_t;
	typedef logic        [7:0]  mask_t;
	typedef logic        [3:0]  count_t;
	typedef logic        [3:0]  slot_t;
	typedef logic signed [17:0] dist_t;
	typedef logic        [27:0] wr_t;
	typedef logic        [29:0] fr_t;
	typedef logic signed [33:0] acc_t;
	typedef logic        [0:0]  cfg_idx_t;
	typedef logic        [13:0] cfg_data_t;

	localparam cfg_idx_t CFG_VERTEX_Z   = 1'd0;
	localparam cfg_idx_t CFG_HALF_WIDTH = 1'd1;

	// Boundary factors 0.64, 1.51, 2.94 in unsigned Q2.14.
	localparam logic [15:0] F_Q [3] = '{16'd10486, 16'd24740, 16'd48169};

	// w = floor((2*hw*256 + 135) / 270) via reciprocal, exact for 23-bit dividends.
	localparam logic [22:0] W_BIAS  = 23'd135;
	localparam logic [23:0] W_RECIP = 24'd15907287;
	localparam wslope_t     W_MAX   = 14'd15533;

	localparam logic [2:0] SLICE_ORDER [SLICE_COUNT] =
		'{3'd7, 3'd5, 3'd3, 3'd1, 3'd0, 3'd2, 3'd4, 3'd6};

	function automatic wslope_t width_slope(input hw_t hw);
		logic [22:0] x;
		logic [46:0] prod;
		begin
			x    = {1'b0, hw, 9'b0} + W_BIAS;
			prod = 47'(x) * 47'(W_RECIP);
			return prod[45:32];
		end
	endfunction

endpackage

>>> hw/rtl/pesa_point_if.sv
// Handshake channel carrying one space point.
interface pesa_point_if;
	import pesa_pkg::*;

	logic     valid;
	logic     ready;
	layer_t   layer_index;
	coord_z_t point_z;
	radius_t  point_r;

	modport source(output valid, output layer_index, output point_z, output point_r,
		input ready);
	modport sink(input valid, input layer_index, input point_z, input point_r,
		output ready);
endinterface

>>> hw/rtl/pesa_slice_if.sv
// Handshake channel carrying one slice assignment result.
interface pesa_slice_if;
	import pesa_pkg::*;

	logic   valid;
	logic   ready;
	layer_t out_layer;
	mask_t  slice_mask;
	count_t slice_count;

	modport source(output valid, output out_layer, output slice_mask, output slice_count,
		input ready);
	modport sink(input valid, input out_layer, input slice_mask, input slice_count,
		output ready);
endinterface

>>> hw/rtl/projective_eta_slice_assigner.sv
// Projective eta slice assigner: four-stage pipeline from point to slice mask.
// An accepted point is registered in stage 1, then stages 2 and 3, and stage 4 drives the result.
// Throughput: one point per cycle; each stage holds only when its successor is full.
// The width slope is computed when half_width is written, so no per-item divider.
// Reset (arst_n low) clears all stage valid bits and the vertex, half-width and slope registers to zero.
module projective_eta_slice_assigner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pesa_pkg::cfg_idx_t  cfg_index,
	input  pesa_pkg::cfg_data_t cfg_data,
	pesa_point_if.sink          point,
	pesa_slice_if.source        result
);
	import pesa_pkg::*;

	vtx_t    vz_q;
	hw_t     hw_q;
	wslope_t w_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	layer_t layer_s1, layer_s2, layer_s3, layer_s4;
	dist_t  d_s1;
	wr_t    wr_s1;
	fr_t    fr_s1 [3];

	acc_t lhs_s2, sa_s2, up_s2, dn_s2;
	acc_t sb_s2 [3];
	acc_t sc_s2 [3];
	acc_t nr_s2 [3];
	logic neg_s2;

	slot_t first_s3, last_s3;
	mask_t  mask_s4;
	count_t count_s4;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vz_q <= '0;
			hw_q <= '0;
			w_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VERTEX_Z: vz_q <= vtx_t'(cfg_data);
				CFG_HALF_WIDTH: begin
					hw_q <= cfg_data[12:0];
					w_q  <= width_slope(cfg_data[12:0]);
				end
				default: ;
			endcase
		end
	end

	// flow control
	assign adv4        = !v_s4 || result.ready;
	assign adv3        = !v_s3 || adv4;
	assign adv2        = !v_s2 || adv3;
	assign adv1        = !v_s1 || adv2;
	assign point.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= point.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: offset from vertex, slope products
	always_ff @(posedge clk) begin
		if (adv1 && point.valid) begin
			layer_s1 <= point.layer_index;
			d_s1     <= dist_t'(point.point_z) - dist_t'(vz_q);
			wr_s1    <= wr_t'(w_q) * wr_t'(point.point_r);
			for (int k = 0; k < 3; k++)
				fr_s1[k] <= fr_t'(point.point_r) * fr_t'(F_Q[k]);
		end
	end

	// stage 2: boundary sums
	acc_t  h_c, wr_c, dx_c, hwx_c, diff_c;
	acc_t  lhs_c, sa_c, up_c, dn_c;
	acc_t  sb_c [3];
	acc_t  sc_c [3];
	acc_t  nr_c [3];
	dist_t dabs_c;

	always_comb begin
		dabs_c = d_s1[17] ? -d_s1 : d_s1;
		lhs_c  = {3'b0, dabs_c[16:0], 14'b0};
		h_c    = {7'b0, hw_q, 14'b0};
		wr_c   = {6'b0, wr_s1};
		dx_c   = {{16{d_s1[17]}}, d_s1};
		hwx_c  = {21'b0, hw_q};
		sa_c   = h_c - wr_c;
		up_c   = (dx_c + hwx_c) <<< Q_FRAC;
		dn_c   = (hwx_c - dx_c) <<< Q_FRAC;
		diff_c = '0;
		for (int k = 0; k < 3; k++) begin
			nr_c[k] = {4'b0, fr_s1[k]} + wr_c;
			sb_c[k] = h_c + {4'b0, fr_s1[k]} - wr_c;
			diff_c  = nr_c[k] - h_c;
			sc_c[k] = diff_c[33] ? -diff_c : diff_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			layer_s2 <= layer_s1;
			neg_s2   <= d_s1[17];
			lhs_s2   <= lhs_c;
			sa_s2    <= sa_c;
			up_s2    <= up_c;
			dn_s2    <= dn_c;
			sb_s2    <= sb_c;
			sc_s2    <= sc_c;
			nr_s2    <= nr_c;
		end
	end

	// stage 3: comparisons, first and last slice position
	slot_t ffar_c, lfar_c, first_c, last_c;

	always_comb begin
		ffar_c = (lhs_s2 > sb_s2[1]) ? ((lhs_s2 > sb_s2[2]) ? 4'd7 : 4'd6)
		                             : ((lhs_s2 > sb_s2[0]) ? 4'd5 : 4'd4);
		lfar_c = (lhs_s2 > sc_s2[1]) ? ((lhs_s2 > sc_s2[2]) ? 4'd8 : 4'd7)
		                             : ((lhs_s2 > sc_s2[0]) ? 4'd6 : 4'd5);
		if (lhs_s2 > sa_s2) begin
			if (neg_s2) begin
				first_c = 4'd8 - lfar_c;
				last_c  = 4'd8 - ffar_c;
			end else begin
				first_c = ffar_c;
				last_c  = lfar_c;
			end
		end else begin
			last_c  = (up_s2 > nr_s2[1]) ? ((up_s2 > nr_s2[2]) ? 4'd8 : 4'd7)
			                             : ((up_s2 > nr_s2[0]) ? 4'd6 : 4'd5);
			first_c = (dn_s2 > nr_s2[1]) ? ((dn_s2 > nr_s2[2]) ? 4'd0 : 4'd1)
			                             : ((dn_s2 > nr_s2[0]) ? 4'd2 : 4'd3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			layer_s3 <= layer_s2;
			first_s3 <= first_c;
			last_s3  <= last_c;
		end
	end

	// stage 4: slice range to mask through the order table
	mask_t  mask_c;
	count_t count_c;

	always_comb begin
		mask_c = '0;
		for (int k = 0; k < SLICE_COUNT; k++) begin
			if (4'(k) >= first_s3 && 4'(k) < last_s3)
				mask_c[SLICE_ORDER[k]] = 1'b1;
		end
		count_c = (last_s3 > first_s3) ? count_t'(last_s3 - first_s3) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			layer_s4 <= layer_s3;
			mask_s4  <= mask_c;
			count_s4 <= count_c;
		end
	end

	assign result.valid       = v_s4;
	assign result.out_layer   = layer_s4;
	assign result.slice_mask  = mask_s4;
	assign result.slice_count = count_s4;

	a_count_matches_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.slice_count == 4'($countones(result.slice_mask)))
		else $error("slice count differs from mask population");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (first_s3 <= 4'd8) && (last_s3 <= 4'd8))
		else $error("slice position out of range");

	a_width_slope_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == CFG_HALF_WIDTH |=> w_q <= W_MAX)
		else $error("width slope exceeds bound");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid && point.ready |=> v_s1)
		else $error("accepted transaction missing from stage 1");

	a_stall_keeps_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && v_s4 && !result.ready |=> v_s3 && v_s4)
		else $error("stalled transaction dropped");

endmodule

>>> sim/pesa_slice_checker.sv
// Checker for the eta slice assigner: predicts each point's slice mask and compares results.
`timescale 1ns / 1ps

module pesa_slice_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  pesa_pkg::cfg_idx_t  cfg_index,
	input  pesa_pkg::cfg_data_t cfg_data,
	pesa_point_if               point,
	pesa_slice_if               result,
	input  logic                end_of_test,
	output int                  fail_count,
	output int                  pending
);
	import pesa_pkg::*;

	localparam longint Q_ONE = 16384;
	localparam longint FACTOR_Q [3] = '{10486, 24740, 48169};
	localparam int SLOT_BIT [8] = '{7, 5, 3, 1, 0, 2, 4, 6};
	localparam int MAX_PRINTED = 50;

	typedef struct packed {
		layer_t layer;
		mask_t  mask;
		count_t count;
	} slice_pred_t;

	vtx_t        vtx_z;
	hw_t         half_w;
	slice_pred_t pending_slices [$];
	slice_pred_t want;
	bit          end_reported;

	function automatic longint mag(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic slice_pred_t assign_slices(layer_t lay, coord_z_t pz, radius_t pr);
		longint v, hw, z, r, w, d, lhs, h, up, dn;
		longint lo [3];
		longint hi [3];
		int first, last, t, k;
		slice_pred_t p;
		v = vtx_z;
		hw = half_w;
		z = pz;
		r = pr;
		w = (hw * Q_ONE + 4320) / 8640;
		for (k = 0; k < 3; k++) begin
			lo[k] = FACTOR_Q[k] - w;
			hi[k] = FACTOR_Q[k] + w;
		end
		d = z - v;
		lhs = mag(d) * Q_ONE;
		h = hw * Q_ONE;
		if (lhs > h - w * r) begin
			if (lhs > h + lo[1] * r)
				first = (lhs > h + lo[2] * r) ? 7 : 6;
			else
				first = (lhs > h + lo[0] * r) ? 5 : 4;
			if (lhs > mag(hi[1] * r - h))
				last = (lhs > mag(hi[2] * r - h)) ? 8 : 7;
			else
				last = (lhs > mag(hi[0] * r - h)) ? 6 : 5;
			// below the vertex: mirror the slice range
			if (d < 0) begin
				t = 8 - first;
				first = 8 - last;
				last = t;
			end
		end else begin
			up = (d + hw) * Q_ONE;
			dn = (hw - d) * Q_ONE;
			if (up > hi[1] * r)
				last = (up > hi[2] * r) ? 8 : 7;
			else
				last = (up > hi[0] * r) ? 6 : 5;
			if (dn > hi[1] * r)
				first = (dn > hi[2] * r) ? 0 : 1;
			else
				first = (dn > hi[0] * r) ? 2 : 3;
		end
		p.layer = lay;
		p.mask = '0;
		p.count = '0;
		if (last > first) begin
			for (k = first; k < last && k < SLICE_COUNT; k++) begin
				if (k >= 0) begin
					p.mask[SLOT_BIT[k]] = 1'b1;
					p.count = p.count + 1'b1;
				end
			end
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, longint got, longint wanted);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, wanted);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			vtx_z = '0;
			half_w = '0;
			pending_slices.delete();
			end_reported = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (pending_slices.size() == 0) begin
					report_mismatch("transaction with nothing pending (layer)",
						result.out_layer, -1);
				end else begin
					want = pending_slices.pop_front();
					if (result.out_layer !== want.layer)
						report_mismatch("out_layer", result.out_layer, want.layer);
					if (result.slice_mask !== want.mask)
						report_mismatch("slice_mask", result.slice_mask, want.mask);
					if (result.slice_count !== want.count)
						report_mismatch("slice_count", result.slice_count, want.count);
				end
			end
			if (point.valid && point.ready)
				pending_slices.insert(pending_slices.size(),
					assign_slices(point.layer_index, point.point_z, point.point_r));
			if (cfg_we) begin
				if (cfg_index == CFG_VERTEX_Z)
					vtx_z = vtx_t'(cfg_data);
				else if (cfg_index == CFG_HALF_WIDTH)
					half_w = cfg_data[12:0];
			end
			if (end_of_test && !end_reported) begin
				end_reported = 1;
				if (pending_slices.size() != 0)
					report_mismatch("results still outstanding", pending_slices.size(), 0);
			end
			pending = pending_slices.size();
		end
	end

endmodule

>>> sim/projective_eta_slice_assigner_test.sv
// Top-level testbench for the projective eta slice assigner: stimulus, back-pressure, verdict.
`timescale 1ns / 1ps

module projective_eta_slice_assigner_test;
	import pesa_pkg::*;

	localparam int POINTS_PER_PHASE = 125;
	localparam int RANDOM_PHASES = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 150;
	localparam longint SLOPE_Q [4] = '{0, 10486, 24740, 48169};

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      end_of_test;
	int        fail_count;
	int        pending;
	bit        calm;
	int        hold_requests;
	longint    cur_vz;
	longint    cur_hw;

	pesa_point_if point_ch();
	pesa_slice_if result_ch();

	projective_eta_slice_assigner uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.point     (point_ch),
		.result    (result_ch)
	);

	pesa_slice_checker slice_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.point       (point_ch),
		.result      (result_ch),
		.end_of_test (end_of_test),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic set_config(longint vz, longint hw, bit hw_top);
		cfg_we <= 1'b1;
		cfg_index <= CFG_VERTEX_Z;
		cfg_data <= vz[13:0];
		@(negedge clk);
		cfg_index <= CFG_HALF_WIDTH;
		cfg_data <= {hw_top, hw[12:0]};
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_vz = vz;
		cur_hw = hw;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic offer_point(layer_t lay, longint z, longint r);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.layer_index <= lay;
		point_ch.point_z <= z[16:0];
		point_ch.point_r <= r[13:0];
		do
			@(posedge clk);
		while (!point_ch.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		point_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic offer_random_point();
		longint w, z, d, r;
		int roll, fi;
		layer_t lay;
		w = (cur_hw * 16384 + 4320) / 8640;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r = 0;
		else if (roll < 15)
			r = $urandom_range(1, 15);
		else if (roll < 20)
			r = 16383;
		else
			r = $urandom_range(1, 16383);
		if ($urandom_range(0, 4) == 0)
			lay = layer_t'($urandom_range(9, 15));
		else
			lay = layer_t'($urandom_range(0, 8));
		roll = $urandom_range(0, 9);
		if (roll < 2) begin
			z = longint'($urandom_range(0, 131071)) - 65536;
		end else if (roll < 8) begin
			// land close to one of the slope boundaries
			fi = $urandom_range(0, 3);
			d = (SLOPE_Q[fi] + ($urandom_range(0, 1) ? w : -w)) * r / 16384;
			d = d + ($urandom_range(0, 1) ? cur_hw : -cur_hw)
				+ longint'($urandom_range(0, 6)) - 3;
			z = cur_vz + ($urandom_range(0, 1) ? d : -d);
		end else begin
			z = cur_vz + longint'($urandom_range(0, 2 * cur_hw + 64)) - cur_hw - 32;
		end
		if (z > 65535)
			z = 65535;
		if (z < -65536)
			z = -65536;
		offer_point(lay, z, r);
	endtask

	initial begin : result_side
		int stall_left, holds_seen;
		stall_left = 0;
		holds_seen = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_seen != hold_requests) begin
				holds_seen = hold_requests;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int ph, i;
		longint vz, hw;
		cfg_we = 1'b0;
		cfg_index = CFG_VERTEX_Z;
		cfg_data = '0;
		end_of_test = 1'b0;
		point_ch.valid = 1'b0;
		point_ch.layer_index = '0;
		point_ch.point_z = '0;
		point_ch.point_r = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// directed: narrow region at z = 0
		set_config(0, 0, 1'b0);
		offer_point(0, 0, 1);
		offer_point(8, 65535, 1);
		offer_point(15, -65536, 1);
		offer_point(1, 0, 16383);
		offer_point(2, -65536, 16383);
		offer_point(3, 65535, 16383);
		offer_point(4, 5243, 8192);
		offer_point(5, 5244, 8192);
		offer_point(6, 12370, 8192);
		offer_point(7, -12371, 8192);
		offer_point(9, 24084, 8192);
		offer_point(10, 24085, 8192);
		offer_point(0, 0, 0);
		offer_point(11, -300, 0);
		settle();

		// directed: widest region, empty range and mirrored points
		set_config(8191, 8191, 1'b0);
		offer_point(12, 8191, 16383);
		offer_point(13, 16191, 16383);
		offer_point(14, 191, 16383);
		offer_point(0, 8191, 1);
		offer_point(1, 12191, 100);
		offer_point(2, 65535, 0);
		settle();

		set_config(-8192, 0, 1'b1);
		offer_point(3, -8192, 1);
		offer_point(4, -65536, 50);
		offer_point(5, 65535, 16383);
		settle();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin vz = -8192; hw = 8191; end
				1: begin vz = 8191; hw = 0; end
				2: begin vz = 0; hw = 8191; end
				3: begin vz = 8191; hw = 8191; end
				default: begin
					vz = longint'($urandom_range(0, 16383)) - 8192;
					if ($urandom_range(0, 3) == 0)
						hw = $urandom_range(0, 63);
					else
						hw = $urandom_range(0, 8191);
				end
			endcase
			set_config(vz, hw, $urandom_range(0, 3) == 0);
			if (ph == 2 || ph == 6)
				hold_requests++;
			for (i = 0; i < POINTS_PER_PHASE; i++) begin
				if (i % 25 == 0)
					calm = ($urandom_range(0, 3) == 0);
				offer_random_point();
			end
			calm = 1'b0;
			settle();
		end

		end_of_test <= 1'b1;
		@(posedge clk);
		@(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
